>>> rtl/bts_pkg.sv
package bts_pkg;

  localparam int SIDE_BITS    = 7;
  localparam int FRAC_BITS    = 9;
  localparam int CHANNEL_BITS = 8;

  localparam int ACC_FRAC   = 8;
  localparam int TEXEL_BITS = 24;
  localparam int ADDR_BITS  = 14;
  localparam int COORD_BITS = 16;
  localparam int SUM_BITS   = 24;
  localparam int CHANNELS   = 3;
  localparam int NEIGHBOURS = 4;

  localparam int INDEX_BITS     = 2 * SIDE_BITS;
  localparam int BANK_ADDR_BITS = INDEX_BITS - 2;
  localparam int WEIGHT_BITS    = 2 * FRAC_BITS + 1;
  localparam int PROD_BITS      = WEIGHT_BITS + CHANNEL_BITS;
  localparam int ACCUM_BITS     = 2 * FRAC_BITS + CHANNEL_BITS + 1;
  localparam int SHIFT          = 2 * FRAC_BITS - ACC_FRAC;
  localparam int INTERP_BITS    = ACCUM_BITS - SHIFT;

  localparam logic [ACCUM_BITS-1:0] ROUND = ACCUM_BITS'((2 ** SHIFT) / 2);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   operation;
    logic [ADDR_BITS-1:0]  texel_address;
    logic [TEXEL_BITS-1:0] texel_rgb;
    logic [COORD_BITS-1:0] u_coord;
    logic [COORD_BITS-1:0] v_coord;
    logic [SUM_BITS-1:0]   acc_red;
    logic [SUM_BITS-1:0]   acc_green;
    logic [SUM_BITS-1:0]   acc_blue;
  } req_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum_red;
    logic [SUM_BITS-1:0] sum_green;
    logic [SUM_BITS-1:0] sum_blue;
    logic                saturated;
  } rsp_t;

  // channels that fall outside the texel read as zero
  function automatic logic [CHANNEL_BITS-1:0] channel_of(input logic [TEXEL_BITS-1:0] texel,
                                                         input int unsigned k);
    logic [TEXEL_BITS+CHANNELS*CHANNEL_BITS-1:0] wide;
    wide = {{(CHANNELS*CHANNEL_BITS){1'b0}}, texel};
    return wide[k*CHANNEL_BITS +: CHANNEL_BITS];
  endfunction

  function automatic logic [SIDE_BITS-1:0] coord_int(input logic [COORD_BITS-1:0] c);
    logic [COORD_BITS+FRAC_BITS+SIDE_BITS-1:0] wide;
    wide = {{(FRAC_BITS+SIDE_BITS){1'b0}}, c};
    return wide[FRAC_BITS +: SIDE_BITS];
  endfunction

  function automatic logic [FRAC_BITS-1:0] coord_frac(input logic [COORD_BITS-1:0] c);
    logic [COORD_BITS+FRAC_BITS-1:0] wide;
    wide = {{FRAC_BITS{1'b0}}, c};
    return wide[FRAC_BITS-1:0];
  endfunction

  function automatic logic [INDEX_BITS-1:0] texel_index(input logic [ADDR_BITS-1:0] a);
    logic [ADDR_BITS+INDEX_BITS-1:0] wide;
    wide = {{INDEX_BITS{1'b0}}, a};
    return wide[INDEX_BITS-1:0];
  endfunction

endpackage

>>> rtl/bts_ram.sv
module bts_ram #(
  parameter int DATA_BITS = 24,
  parameter int ADDR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bilinear_texture_sampler.sv
// an accepted sample request moves through stages 1, 2 and 3 to the rsp_valid register; a stall holds it in place
// throughput: one request per cycle while req_stall is low, loads and samples alike; a load gives no response
// the four neighbour texels come from four row/column parity banks, one read port each
// each stage holds while the one after it is full and stalled, so bubbles are squeezed out
// reset clears the stage valid bits only; texels are undefined until loaded
module bilinear_texture_sampler (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bts_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bts_pkg::rsp_t rsp_data
);

  localparam int SB = bts_pkg::SIDE_BITS;
  localparam int WB = bts_pkg::WEIGHT_BITS;
  localparam logic [WB+1:0] WEIGHT_TOTAL = (WB+2)'(2 ** (2 * bts_pkg::FRAC_BITS));
  localparam logic [bts_pkg::INTERP_BITS-1:0] INTERP_MAX =
    bts_pkg::INTERP_BITS'((2 ** bts_pkg::CHANNEL_BITS - 1) * (2 ** bts_pkg::ACC_FRAC));
  localparam logic [bts_pkg::SUM_BITS-1:0] SUM_MAX = '1;

  logic en1, en2, en3, en4;
  logic accept, load_acc, sample_acc;

  // stage 0: address split and weights
  logic [SB-1:0] iu, iv, iu1, iv1;
  logic [WB-1:0] fu, fv, gu, gv;
  logic [WB-1:0] w0 [bts_pkg::NEIGHBOURS];
  logic [bts_pkg::INDEX_BITS-1:0] widx;
  logic [bts_pkg::SUM_BITS-1:0] acc0 [bts_pkg::CHANNELS];
  logic [bts_pkg::TEXEL_BITS-1:0] bank_q [4];

  // stage 1
  logic v1;
  logic [1:0] par1;
  logic [WB-1:0] w1 [bts_pkg::NEIGHBOURS];
  logic [bts_pkg::SUM_BITS-1:0] acc1 [bts_pkg::CHANNELS];

  // stage 2
  logic v2;
  logic [bts_pkg::TEXEL_BITS-1:0] tex [bts_pkg::NEIGHBOURS];
  logic [bts_pkg::PROD_BITS-1:0] prod2 [bts_pkg::CHANNELS][bts_pkg::NEIGHBOURS];
  logic [bts_pkg::SUM_BITS-1:0] acc2 [bts_pkg::CHANNELS];

  // stage 3
  logic v3;
  logic [bts_pkg::ACCUM_BITS-1:0] accum [bts_pkg::CHANNELS];
  logic [bts_pkg::INTERP_BITS-1:0] interp3 [bts_pkg::CHANNELS];
  logic [bts_pkg::SUM_BITS-1:0] acc3 [bts_pkg::CHANNELS];

  // stage 4
  logic [bts_pkg::SUM_BITS:0] sum4 [bts_pkg::CHANNELS];
  logic [bts_pkg::SUM_BITS-1:0] clip4 [bts_pkg::CHANNELS];
  logic sat4;

  assign en4 = !rsp_valid || !rsp_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign req_stall  = !en1;
  assign accept     = req_valid && en1;
  assign load_acc   = accept && (req_data.operation == bts_pkg::OP_LOAD);
  assign sample_acc = accept && (req_data.operation == bts_pkg::OP_SAMPLE);

  always_comb begin
    iu  = bts_pkg::coord_int(req_data.u_coord);
    iv  = bts_pkg::coord_int(req_data.v_coord);
    iu1 = iu + SB'(1);
    iv1 = iv + SB'(1);
    fu  = WB'(bts_pkg::coord_frac(req_data.u_coord));
    fv  = WB'(bts_pkg::coord_frac(req_data.v_coord));
    gu  = WB'(2 ** bts_pkg::FRAC_BITS) - fu;
    gv  = WB'(2 ** bts_pkg::FRAC_BITS) - fv;
    w0[0] = gu * gv;
    w0[1] = fu * gv;
    w0[2] = gu * fv;
    w0[3] = fu * fv;
    widx  = bts_pkg::texel_index(req_data.texel_address);
    acc0[0] = req_data.acc_blue;
    acc0[1] = req_data.acc_green;
    acc0[2] = req_data.acc_red;
  end

  // bank b holds the texels whose row parity is b[1] and column parity b[0]
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = 1'((b >> 1) & 1);
    localparam logic PC = 1'(b & 1);
    logic [SB-1:0] row_sel, col_sel;
    logic [bts_pkg::BANK_ADDR_BITS-1:0] raddr, waddr;
    logic we;

    assign row_sel = (iv[0] == PR) ? iv : iv1;
    assign col_sel = (iu[0] == PC) ? iu : iu1;
    assign raddr   = {row_sel[SB-1:1], col_sel[SB-1:1]};
    assign waddr   = {widx[2*SB-1:SB+1], widx[SB-1:1]};
    assign we      = load_acc && (widx[SB] == PR) && (widx[0] == PC);

    bts_ram #(
      .DATA_BITS(bts_pkg::TEXEL_BITS),
      .ADDR_BITS(bts_pkg::BANK_ADDR_BITS)
    ) u_bank (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(req_data.texel_rgb),
      .re   (en1),
      .raddr(raddr),
      .rdata(bank_q[b])
    );
  end

  always_comb begin
    for (int n = 0; n < bts_pkg::NEIGHBOURS; n++) begin
      tex[n] = bank_q[par1 ^ 2'(n)];
    end
  end

  always_comb begin
    for (int c = 0; c < bts_pkg::CHANNELS; c++) begin
      accum[c] = bts_pkg::ACCUM_BITS'(prod2[c][0]) + bts_pkg::ACCUM_BITS'(prod2[c][1])
               + bts_pkg::ACCUM_BITS'(prod2[c][2]) + bts_pkg::ACCUM_BITS'(prod2[c][3])
               + bts_pkg::ROUND;
    end
  end

  always_comb begin
    sat4 = 1'b0;
    for (int c = 0; c < bts_pkg::CHANNELS; c++) begin
      sum4[c] = {1'b0, acc3[c]} + (bts_pkg::SUM_BITS+1)'(interp3[c]);
      if (sum4[c][bts_pkg::SUM_BITS]) begin
        clip4[c] = SUM_MAX;
        sat4     = 1'b1;
      end else begin
        clip4[c] = sum4[c][bts_pkg::SUM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= sample_acc;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        rsp_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      par1 <= {iv[0], iu[0]};
      w1   <= w0;
      acc1 <= acc0;
    end
    if (en2) begin
      for (int c = 0; c < bts_pkg::CHANNELS; c++) begin
        for (int n = 0; n < bts_pkg::NEIGHBOURS; n++) begin
          prod2[c][n] <= bts_pkg::PROD_BITS'(w1[n])
                       * bts_pkg::PROD_BITS'(bts_pkg::channel_of(tex[n], c));
        end
      end
      acc2 <= acc1;
    end
    if (en3) begin
      for (int c = 0; c < bts_pkg::CHANNELS; c++) begin
        interp3[c] <= bts_pkg::INTERP_BITS'(accum[c] >> bts_pkg::SHIFT);
      end
      acc3 <= acc2;
    end
    if (en4) begin
      rsp_data.sum_blue  <= clip4[0];
      rsp_data.sum_green <= clip4[1];
      rsp_data.sum_red   <= clip4[2];
      rsp_data.saturated <= sat4;
    end
  end

  // the four weights always make up one whole
  a_weight_total: assert property (@(posedge clk) disable iff (rst)
    v1 |-> ((WB+2)'(w1[0]) + (WB+2)'(w1[1]) + (WB+2)'(w1[2]) + (WB+2)'(w1[3]))
           == WEIGHT_TOTAL)
    else $error("bilinear weights do not sum to one");

  a_interp_bound: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (interp3[0] <= INTERP_MAX) && (interp3[1] <= INTERP_MAX)
           && (interp3[2] <= INTERP_MAX))
    else $error("interpolated channel beyond the largest texel value");

  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.saturated |-> (rsp_data.sum_red == SUM_MAX)
      || (rsp_data.sum_green == SUM_MAX) || (rsp_data.sum_blue == SUM_MAX))
    else $error("saturated flag without a clipped channel");

  // requests are held back only when every stage is full behind a stalled response
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> v1 && v2 && v3 && rsp_valid && rsp_stall)
    else $error("request stalled while the pipeline has a bubble");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    v3 && en4 |=> rsp_valid)
    else $error("finished sample lost on its way to the response register");

endmodule

>>> tb/bilinear_texture_sampler_tb.sv
module bilinear_texture_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXELS     = 1 << bts_pkg::INDEX_BITS;
  localparam int DRAIN_WAIT = 10000;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bts_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bts_pkg::rsp_t rsp_data;

  // mirror of the texture, kept in request order
  logic [bts_pkg::TEXEL_BITS-1:0] texel_mirror [TEXELS];
  bts_pkg::rsp_t pending_sums [$];
  bts_pkg::rsp_t front_sum;

  int errors = 0;
  int loads_sent = 0;
  int samples_sent = 0;
  int clipped_seen = 0;
  int stall_left = 0;
  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;

  bilinear_texture_sampler dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("timeout with %0d responses outstanding", pending_sums.size());
    $display("** bilinear_texture_sampler: FAILED **");
    $finish;
  end

  task automatic note_failure(input string what);
    errors++;
    if (errors <= 10) begin
      $display("%t: %s", $realtime, what);
    end
  endtask

  function automatic logic [bts_pkg::TEXEL_BITS-1:0] texel_at(input int unsigned col,
                                                              input int unsigned row);
    int unsigned smask;
    smask = (1 << bts_pkg::SIDE_BITS) - 1;
    return texel_mirror[bts_pkg::INDEX_BITS'(((row & smask) << bts_pkg::SIDE_BITS)
                                             | (col & smask))];
  endfunction

  function automatic bts_pkg::rsp_t bilinear_sum(input bts_pkg::req_t r);
    longint unsigned one, fu, fv, cmask, acc, interp, total;
    longint unsigned w [4];
    int unsigned iu, iv, smask, k;
    logic [bts_pkg::TEXEL_BITS-1:0] tx [4];
    logic [bts_pkg::SUM_BITS-1:0] acc_in [3];
    logic [bts_pkg::SUM_BITS-1:0] sums [3];
    bts_pkg::rsp_t res;
    one   = 64'd1 << bts_pkg::FRAC_BITS;
    smask = (1 << bts_pkg::SIDE_BITS) - 1;
    cmask = (64'd1 << bts_pkg::CHANNEL_BITS) - 1;
    fu = r.u_coord & (one - 1);
    fv = r.v_coord & (one - 1);
    iu = (r.u_coord >> bts_pkg::FRAC_BITS) & smask;
    iv = (r.v_coord >> bts_pkg::FRAC_BITS) & smask;
    w[0] = (one - fu) * (one - fv);
    w[1] = fu * (one - fv);
    w[2] = (one - fu) * fv;
    w[3] = fu * fv;
    tx[0] = texel_at(iu, iv);
    tx[1] = texel_at(iu + 1, iv);
    tx[2] = texel_at(iu, iv + 1);
    tx[3] = texel_at(iu + 1, iv + 1);
    acc_in[0] = r.acc_red;
    acc_in[1] = r.acc_green;
    acc_in[2] = r.acc_blue;
    res = '0;
    for (int j = 0; j < bts_pkg::CHANNELS; j++) begin
      k = 2 - j;
      acc = 0;
      for (int n = 0; n < bts_pkg::NEIGHBOURS; n++) begin
        acc += w[n] * ((64'(tx[n]) >> (k * bts_pkg::CHANNEL_BITS)) & cmask);
      end
      // round half up to the accumulator's fraction bits
      if (bts_pkg::SHIFT == 0) begin
        interp = acc;
      end else begin
        interp = (acc + (64'd1 << (bts_pkg::SHIFT - 1))) >> bts_pkg::SHIFT;
      end
      total = 64'(acc_in[j]) + interp;
      if (total > 64'hFF_FFFF) begin
        total = 64'hFF_FFFF;
        res.saturated = 1'b1;
      end
      sums[j] = total[bts_pkg::SUM_BITS-1:0];
    end
    res.sum_red   = sums[0];
    res.sum_green = sums[1];
    res.sum_blue  = sums[2];
    return res;
  endfunction

  task automatic note_request(input bts_pkg::req_t r);
    if (r.operation == bts_pkg::OP_LOAD) begin
      texel_mirror[r.texel_address[bts_pkg::INDEX_BITS-1:0]] = r.texel_rgb;
      loads_sent++;
    end else begin
      pending_sums.push_back(bilinear_sum(r));
      samples_sent++;
    end
  endtask

  task automatic send_request(input bts_pkg::req_t r);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    note_request(r);
  endtask

  function automatic bts_pkg::req_t load_req(input int unsigned addr, input logic [23:0] rgb);
    bts_pkg::req_t r;
    r = '0;
    r.operation     = bts_pkg::OP_LOAD;
    r.texel_address = bts_pkg::ADDR_BITS'(addr);
    r.texel_rgb     = rgb;
    return r;
  endfunction

  function automatic bts_pkg::req_t sample_req(input logic [15:0] u, input logic [15:0] v,
                                               input logic [23:0] red,
                                               input logic [23:0] green,
                                               input logic [23:0] blue);
    bts_pkg::req_t r;
    r = '0;
    r.operation = bts_pkg::OP_SAMPLE;
    r.u_coord   = u;
    r.v_coord   = v;
    r.acc_red   = red;
    r.acc_green = green;
    r.acc_blue  = blue;
    return r;
  endfunction

  // samples sit on these base rows and columns; each base and the line after it get loaded
  function automatic logic [bts_pkg::SIDE_BITS-1:0] base_line(input int unsigned n);
    case (n)
      0: return bts_pkg::SIDE_BITS'(127);
      1: return bts_pkg::SIDE_BITS'(0);
      2: return bts_pkg::SIDE_BITS'(42);
      default: return bts_pkg::SIDE_BITS'(85);
    endcase
  endfunction

  function automatic logic [bts_pkg::SIDE_BITS-1:0] region_line(input int unsigned n);
    return base_line(n >> 1) + bts_pkg::SIDE_BITS'(n & 1);
  endfunction

  function automatic int unsigned region_addr(input int unsigned row_n,
                                              input int unsigned col_n);
    return 32'({region_line(row_n), region_line(col_n)});
  endfunction

  function automatic logic [bts_pkg::COORD_BITS-1:0] random_coord();
    return bts_pkg::COORD_BITS'({base_line($urandom_range(0, 3)),
      bts_pkg::FRAC_BITS'($urandom_range(0, (1 << bts_pkg::FRAC_BITS) - 1))});
  endfunction

  function automatic logic [23:0] random_total();
    case ($urandom_range(0, 7))
      0: return 24'hFF_FFFF - 24'($urandom_range(0, 65535));
      1: return '0;
      2: return 24'hFF_FFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] random_texel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'hFF_FFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // response side: random stall after each response, checked in order
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_sums.size() == 0) begin
          note_failure($sformatf("response with none expected: r %h g %h b %h sat %b",
                       rsp_data.sum_red, rsp_data.sum_green, rsp_data.sum_blue,
                       rsp_data.saturated));
        end else begin
          front_sum = pending_sums.pop_front();
          if (front_sum.saturated) clipped_seen++;
          if (rsp_data.sum_red !== front_sum.sum_red ||
              rsp_data.sum_green !== front_sum.sum_green ||
              rsp_data.sum_blue !== front_sum.sum_blue ||
              rsp_data.saturated !== front_sum.saturated) begin
            note_failure($sformatf(
              "sum mismatch: expected r %h g %h b %h sat %b, got r %h g %h b %h sat %b",
              front_sum.sum_red, front_sum.sum_green, front_sum.sum_blue,
              front_sum.saturated, rsp_data.sum_red, rsp_data.sum_green,
              rsp_data.sum_blue, rsp_data.saturated));
          end
        end
        stall_left = quiet_recv ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // every texel a sample can reach gets written first, so none reads an unloaded one
  task automatic fill_texture();
    quiet_send = 1'b1;
    for (int rn = 0; rn < 8; rn++) begin
      for (int cn = 0; cn < 8; cn++) begin
        send_request(load_req(region_addr(rn, cn), random_texel()));
      end
    end
    quiet_send = 1'b0;
  endtask

  task automatic check_wrap_corners();
    send_request(load_req(0, 24'hFF_FFFF));
    send_request(load_req(127, 24'h00_0000));
    send_request(load_req(16256, 24'hFF_00FF));
    send_request(load_req(16383, 24'h12_80EE));
    send_request(sample_req({7'd127, 9'h100}, {7'd127, 9'h100}, 0, 0, 0));
    send_request(sample_req(16'hFFFF, 16'hFFFF, 0, 0, 0));
    send_request(sample_req(16'h0000, 16'h0000, 0, 0, 0));
    send_request(sample_req(16'h01FF, 16'h0000, 24'h00_0001, 0, 24'h00_0100));
  endtask

  task automatic check_fraction_extremes();
    logic [8:0] fr [2];
    fr[0] = 9'h000;
    fr[1] = 9'h1FF;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        send_request(sample_req({7'd42, fr[a]}, {7'd85, fr[b]}, 24'h12_3456, 0,
                                24'hAB_CDEF));
      end
    end
  endtask

  task automatic check_load_then_sample();
    send_request(load_req(0, 24'h00_0000));
    send_request(sample_req(16'h0000, 16'h0000, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
    send_request(load_req(16383, 24'hFF_FFFF));
    send_request(sample_req(16'hFE00, 16'hFE00, 24'h00_0000, 24'h00_0000, 24'h00_0000));
  endtask

  task automatic check_saturation();
    bts_pkg::req_t r;
    bts_pkg::rsp_t bare;
    send_request(sample_req(16'hFE00, 16'hFE00, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
    // sums land exactly on the ceiling, then one past it on red only
    r = sample_req(random_coord(), random_coord(), 0, 0, 0);
    bare = bilinear_sum(r);
    r.acc_red   = 24'hFF_FFFF - bare.sum_red;
    r.acc_green = 24'hFF_FFFF - bare.sum_green;
    r.acc_blue  = 24'hFF_FFFF - bare.sum_blue;
    send_request(r);
    r.acc_red = r.acc_red + 24'd1;
    send_request(r);
  endtask

  task automatic run_random_mix(input int count);
    bts_pkg::req_t r;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        quiet_send = ($urandom_range(0, 3) == 0);
        quiet_recv = ($urandom_range(0, 3) == 0);
      end
      r.operation     = ($urandom_range(0, 9) < 6) ? bts_pkg::OP_SAMPLE : bts_pkg::OP_LOAD;
      r.texel_address = bts_pkg::ADDR_BITS'(region_addr($urandom_range(0, 7),
                                                         $urandom_range(0, 7)));
      r.texel_rgb     = random_texel();
      r.u_coord       = random_coord();
      r.v_coord       = random_coord();
      r.acc_red       = random_total();
      r.acc_green     = random_total();
      r.acc_blue      = random_total();
      send_request(r);
    end
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fill_texture();
    check_wrap_corners();
    check_fraction_extremes();
    check_load_then_sample();
    check_saturation();
    run_random_mix(420);
    req_valid <= 1'b0;
    waited = 0;
    while (pending_sums.size() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_sums.size() != 0) begin
      note_failure($sformatf("%0d responses never arrived", pending_sums.size()));
    end
    // give any stray response time to show up
    repeat (12) @(posedge clk);
    $display("run covered %0d texel loads and %0d bilinear samples", loads_sent, samples_sent);
    $display("%0d samples clipped at the ceiling, %0d failures", clipped_seen, errors);
    if (errors == 0) begin
      $display("** bilinear_texture_sampler: PASSED **");
    end else begin
      $display("** bilinear_texture_sampler: FAILED **");
    end
    $finish;
  end

endmodule
